@@ hw/rtl/perspective_project_outcode_assert.svh @@
// Assertion macros for the perspective projection block.
// Included by the checker; no other dependencies.
`ifndef PERSPECTIVE_PROJECT_OUTCODE_ASSERT_SVH
`define PERSPECTIVE_PROJECT_OUTCODE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PPO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PPO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// checked during reset as well
`define PPO_ASSERT_RST(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/ppo_pkg.sv @@
// Package for the perspective projection block: widths, register codes, cell type.
// No dependencies.
`timescale 1ns / 1ps

package ppo_pkg;

	localparam int CoordW = 16;
	localparam int ScaleW = 12;
	localparam int DepthW = 15;
	localparam int QuoW   = 27;
	localparam int ScrW   = 28;
	localparam int CodeW  = 5;
	localparam int IdxW   = 3;
	localparam int DataW  = 32;
	localparam int NumCells = QuoW;

	localparam int NEAR_B = 4;
	localparam int YHI_B  = 3;
	localparam int YLO_B  = 2;
	localparam int XHI_B  = 1;
	localparam int XLO_B  = 0;

	typedef enum logic [IdxW-1:0] {
		REG_X_SCALE  = 3'd0,
		REG_Y_SCALE  = 3'd1,
		REG_X_CENTER = 3'd2,
		REG_Y_CENTER = 3'd3,
		REG_MIN_DEPTH = 3'd4,
		REG_WIN_X    = 3'd5,
		REG_WIN_Y    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [QuoW-1:0]   num_x;
		logic [QuoW-1:0]   num_y;
		logic [DepthW-1:0] rem_x;
		logic [DepthW-1:0] rem_y;
		logic [DepthW-1:0] dv;
		logic              neg_x;
		logic              neg_y;
		logic              near;
		logic [CoordW-1:0] z;
	} cell_t;

endpackage

@@ hw/rtl/ppo_if.sv @@
// Channel interfaces: vertex in, screen result out, register write.
// Depends on ppo_pkg.
`timescale 1ns / 1ps

interface ppo_vtx_if;
	logic                              valid;
	logic                              ready;
	logic signed [ppo_pkg::CoordW-1:0] x_coord;
	logic signed [ppo_pkg::CoordW-1:0] y_coord;
	logic signed [ppo_pkg::CoordW-1:0] z_coord;
	modport source (output valid, x_coord, y_coord, z_coord, input ready);
	modport sink (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface ppo_scr_if;
	logic                              valid;
	logic                              ready;
	logic signed [ppo_pkg::ScrW-1:0]   screen_x;
	logic signed [ppo_pkg::ScrW-1:0]   screen_y;
	logic [ppo_pkg::CodeW-1:0]         clip_code;
	logic signed [ppo_pkg::CoordW-1:0] depth_out;
	modport source (output valid, screen_x, screen_y, clip_code, depth_out, input ready);
	modport sink (input valid, screen_x, screen_y, clip_code, depth_out, output ready);
endinterface

interface ppo_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ppo_pkg::IdxW-1:0]   index;
	logic [ppo_pkg::DataW-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ppo_front.sv @@
// Head of the chain: near clamp, scale multiply, sign split.
// Depends on ppo_pkg.
`timescale 1ns / 1ps

module ppo_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic signed [ppo_pkg::CoordW-1:0] x_coord,
	input  logic signed [ppo_pkg::CoordW-1:0] y_coord,
	input  logic signed [ppo_pkg::CoordW-1:0] z_coord,
	input  logic [ppo_pkg::ScaleW-1:0]        x_scale,
	input  logic [ppo_pkg::ScaleW-1:0]        y_scale,
	input  logic [ppo_pkg::DepthW-1:0]        min_depth,
	output logic                              valid_s1,
	output ppo_pkg::cell_t                    cell_s1
);

	logic [ppo_pkg::DepthW-1:0]            near_lim;
	logic                                  zlt;
	logic [ppo_pkg::CoordW:0]              ax;
	logic [ppo_pkg::CoordW:0]              ay;
	logic [ppo_pkg::CoordW+ppo_pkg::ScaleW:0] px;
	logic [ppo_pkg::CoordW+ppo_pkg::ScaleW:0] py;
	ppo_pkg::cell_t                        nxt;

	always_comb begin
		near_lim = (min_depth == '0) ? ppo_pkg::DepthW'(1) : min_depth;
		zlt = z_coord < $signed({1'b0, near_lim});
		ax = x_coord[ppo_pkg::CoordW-1] ? ((ppo_pkg::CoordW+1)'(0) - {x_coord[ppo_pkg::CoordW-1], x_coord})
			: {1'b0, x_coord};
		ay = y_coord[ppo_pkg::CoordW-1] ? ((ppo_pkg::CoordW+1)'(0) - {y_coord[ppo_pkg::CoordW-1], y_coord})
			: {1'b0, y_coord};
		px = ax * {1'b0, x_scale};
		py = ay * {1'b0, y_scale};
		nxt.num_x = px[ppo_pkg::QuoW-1:0];
		nxt.num_y = py[ppo_pkg::QuoW-1:0];
		nxt.rem_x = '0;
		nxt.rem_y = '0;
		nxt.dv    = zlt ? near_lim : z_coord[ppo_pkg::DepthW-1:0];
		nxt.neg_x = x_coord[ppo_pkg::CoordW-1];
		nxt.neg_y = y_coord[ppo_pkg::CoordW-1];
		nxt.near  = zlt;
		nxt.z     = z_coord;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_s1 <= nxt;
		end
	end

endmodule

@@ hw/rtl/ppo_div_cell.sv @@
// One restoring-division cell: one quotient bit for both x and y lanes.
// Depends on ppo_pkg.
`timescale 1ns / 1ps

module ppo_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  ppo_pkg::cell_t in_cell,
	output logic           valid_q,
	output ppo_pkg::cell_t cell_q
);

	logic [ppo_pkg::DepthW:0] tx;
	logic [ppo_pkg::DepthW:0] ty;
	logic [ppo_pkg::DepthW:0] dext;
	logic                     gx;
	logic                     gy;
	logic [ppo_pkg::DepthW:0] rx;
	logic [ppo_pkg::DepthW:0] ry;
	ppo_pkg::cell_t           nxt;

	always_comb begin
		dext = {1'b0, in_cell.dv};
		tx = {in_cell.rem_x, in_cell.num_x[ppo_pkg::QuoW-1]};
		ty = {in_cell.rem_y, in_cell.num_y[ppo_pkg::QuoW-1]};
		gx = tx >= dext;
		gy = ty >= dext;
		rx = gx ? (tx - dext) : tx;
		ry = gy ? (ty - dext) : ty;
		nxt = in_cell;
		nxt.rem_x = rx[ppo_pkg::DepthW-1:0];
		nxt.rem_y = ry[ppo_pkg::DepthW-1:0];
		nxt.num_x = {in_cell.num_x[ppo_pkg::QuoW-2:0], gx};
		nxt.num_y = {in_cell.num_y[ppo_pkg::QuoW-2:0], gy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_q <= nxt;
		end
	end

endmodule

@@ hw/rtl/ppo_back.sv @@
// Tail of the chain: sign restore, center offset, outcode, output register.
// Depends on ppo_pkg.
`timescale 1ns / 1ps

module ppo_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  ppo_pkg::cell_t                    in_cell,
	input  logic [ppo_pkg::CoordW-1:0]        x_center,
	input  logic [ppo_pkg::CoordW-1:0]        y_center,
	input  logic [ppo_pkg::DataW-1:0]         win_x,
	input  logic [ppo_pkg::DataW-1:0]         win_y,
	output logic                              valid_q,
	output logic signed [ppo_pkg::ScrW-1:0]   screen_x_q,
	output logic signed [ppo_pkg::ScrW-1:0]   screen_y_q,
	output logic [ppo_pkg::CodeW-1:0]         clip_code_q,
	output logic signed [ppo_pkg::CoordW-1:0] depth_q
);

	localparam int ExtW = ppo_pkg::ScrW - ppo_pkg::CoordW;

	logic signed [ppo_pkg::ScrW-1:0] qx;
	logic signed [ppo_pkg::ScrW-1:0] qy;
	logic signed [ppo_pkg::ScrW-1:0] sx;
	logic signed [ppo_pkg::ScrW-1:0] sy;
	logic signed [ppo_pkg::ScrW-1:0] xmin, xmax, ymin, ymax;
	logic [ppo_pkg::CodeW-1:0]       code;

	always_comb begin
		qx = in_cell.neg_x ? (ppo_pkg::ScrW'(0) - {1'b0, in_cell.num_x}) : {1'b0, in_cell.num_x};
		qy = in_cell.neg_y ? (ppo_pkg::ScrW'(0) - {1'b0, in_cell.num_y}) : {1'b0, in_cell.num_y};
		sx = qx + {{ExtW{x_center[ppo_pkg::CoordW-1]}}, x_center};
		sy = qy + {{ExtW{y_center[ppo_pkg::CoordW-1]}}, y_center};
		xmin = {{ExtW{win_x[15]}}, win_x[15:0]};
		xmax = {{ExtW{win_x[31]}}, win_x[31:16]};
		ymin = {{ExtW{win_y[15]}}, win_y[15:0]};
		ymax = {{ExtW{win_y[31]}}, win_y[31:16]};
		code = '0;
		code[ppo_pkg::NEAR_B] = in_cell.near;
		code[ppo_pkg::YHI_B]  = sy > ymax;
		code[ppo_pkg::YLO_B]  = sy < ymin;
		code[ppo_pkg::XHI_B]  = sx > xmax;
		code[ppo_pkg::XLO_B]  = sx < xmin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			screen_x_q  <= sx;
			screen_y_q  <= sy;
			clip_code_q <= code;
			depth_q     <= in_cell.z;
		end
	end

endmodule

@@ hw/rtl/perspective_project_outcode.sv @@
// Top level of the perspective projection block with clip outcodes.
// Depends on ppo_pkg, ppo_if, ppo_front, ppo_div_cell, ppo_back.
//
// Channels: vtx takes one camera-space vertex per beat, scr returns one
// projected vertex per beat (screen x/y, outcode, original depth), cfg
// writes one register per beat and is always ready.
// Pipeline: one multiply stage, 27 division cells and one output stage
// lie between an accepted vertex and its result on scr.
// Throughput: one vertex per cycle while scr keeps taking results; the
// chain of division cells, one quotient bit per cell, sets the latency.
// Each stage keeps its own valid bit and moves whenever the stage ahead
// is empty or moving, so bubbles close up and vtx stays ready while a
// finished result waits on scr, until every stage is occupied.
// Reset clears all valid bits and loads the register defaults; no
// vertex is lost or repeated when scr stalls.
`timescale 1ns / 1ps

module perspective_project_outcode (
	input logic         clk,
	input logic         arst_n,
	ppo_vtx_if.sink     vtx,
	ppo_scr_if.source   scr,
	ppo_cfg_if.sink     cfg
);

	logic [ppo_pkg::ScaleW-1:0] x_scale_q;
	logic [ppo_pkg::ScaleW-1:0] y_scale_q;
	logic [ppo_pkg::CoordW-1:0] x_center_q;
	logic [ppo_pkg::CoordW-1:0] y_center_q;
	logic [ppo_pkg::DepthW-1:0] min_depth_q;
	logic [ppo_pkg::DataW-1:0]  win_x_q;
	logic [ppo_pkg::DataW-1:0]  win_y_q;

	logic           v [0:ppo_pkg::NumCells];
	ppo_pkg::cell_t c [0:ppo_pkg::NumCells];
	logic           adv [0:ppo_pkg::NumCells];
	logic           adv_back;
	logic           out_valid;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q   <= ppo_pkg::ScaleW'(256);
			y_scale_q   <= ppo_pkg::ScaleW'(213);
			x_center_q  <= ppo_pkg::CoordW'(160);
			y_center_q  <= ppo_pkg::CoordW'(130);
			min_depth_q <= ppo_pkg::DepthW'(128);
			win_x_q     <= ppo_pkg::DataW'(32'h013F_0000);
			win_y_q     <= ppo_pkg::DataW'(32'h00C7_0000);
		end else if (cfg.valid) begin
			case (ppo_pkg::reg_idx_t'(cfg.index))
				ppo_pkg::REG_X_SCALE:   x_scale_q   <= cfg.data[ppo_pkg::ScaleW-1:0];
				ppo_pkg::REG_Y_SCALE:   y_scale_q   <= cfg.data[ppo_pkg::ScaleW-1:0];
				ppo_pkg::REG_X_CENTER:  x_center_q  <= cfg.data[ppo_pkg::CoordW-1:0];
				ppo_pkg::REG_Y_CENTER:  y_center_q  <= cfg.data[ppo_pkg::CoordW-1:0];
				ppo_pkg::REG_MIN_DEPTH: min_depth_q <= cfg.data[ppo_pkg::DepthW-1:0];
				ppo_pkg::REG_WIN_X:     win_x_q     <= cfg.data;
				ppo_pkg::REG_WIN_Y:     win_y_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	assign adv_back = !out_valid || scr.ready;
	assign adv[ppo_pkg::NumCells] = !v[ppo_pkg::NumCells] || adv_back;

	genvar gi;
	generate
		for (gi = 0; gi < ppo_pkg::NumCells; gi++) begin : g_adv
			assign adv[gi] = !v[gi] || adv[gi+1];
		end
	endgenerate

	assign vtx.ready = adv[0];

	ppo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv[0]),
		.in_valid  (vtx.valid),
		.x_coord   (vtx.x_coord),
		.y_coord   (vtx.y_coord),
		.z_coord   (vtx.z_coord),
		.x_scale   (x_scale_q),
		.y_scale   (y_scale_q),
		.min_depth (min_depth_q),
		.valid_s1  (v[0]),
		.cell_s1   (c[0])
	);

	generate
		for (gi = 0; gi < ppo_pkg::NumCells; gi++) begin : g_cell
			ppo_div_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv[gi+1]),
				.in_valid (v[gi]),
				.in_cell  (c[gi]),
				.valid_q  (v[gi+1]),
				.cell_q   (c[gi+1])
			);
		end
	endgenerate

	ppo_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv_back),
		.in_valid    (v[ppo_pkg::NumCells]),
		.in_cell     (c[ppo_pkg::NumCells]),
		.x_center    (x_center_q),
		.y_center    (y_center_q),
		.win_x       (win_x_q),
		.win_y       (win_y_q),
		.valid_q     (out_valid),
		.screen_x_q  (scr.screen_x),
		.screen_y_q  (scr.screen_y),
		.clip_code_q (scr.clip_code),
		.depth_q     (scr.depth_out)
	);

	assign scr.valid = out_valid;

endmodule

@@ hw/rtl/ppo_checker.sv @@
// Port-level checker for the perspective projection block, bound to the top.
// Depends on ppo_pkg and perspective_project_outcode_assert.svh.
`timescale 1ns / 1ps
`include "perspective_project_outcode_assert.svh"

module ppo_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [ppo_pkg::CodeW-1:0]         clip_code,
	input logic signed [ppo_pkg::CoordW-1:0] depth_out
);

	`PPO_ASSERT_RST(a_idle_at_reset_exit, clk, $rose(arst_n), !out_valid)
	`PPO_ASSERT_IMP(a_empty_out_ready, clk, arst_n, !out_valid, in_ready)
	`PPO_ASSERT_IMP(a_far_depth_positive, clk, arst_n, out_valid && !clip_code[ppo_pkg::NEAR_B], depth_out > 0)
	`PPO_ASSERT_NXT(a_hold_valid, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule

bind perspective_project_outcode ppo_checker u_ppo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (vtx.ready),
	.out_valid (scr.valid),
	.out_ready (scr.ready),
	.clip_code (scr.clip_code),
	.depth_out (scr.depth_out)
);
